// ----- sv/clim_pkg.sv -----
// Package for the current limit / overcurrent integrator.
// Transaction payload structs, register indexes, over-limit codes, constants.
// No dependencies.
`timescale 1ns / 1ps

package clim_pkg;

    typedef struct packed {
        logic signed [20:0] meas_ma;
        logic               flow_en;
        logic [15:0]        temp_charge_da;
        logic [15:0]        temp_discharge_da;
        logic [15:0]        cellv_charge_da;
        logic [15:0]        cellv_discharge_da;
        logic [15:0]        working_charge_da;
        logic [15:0]        delta_charge_da;
        logic signed [15:0] cell_max_mv;
        logic signed [15:0] cell_min_mv;
    } clim_in_t;

    typedef struct packed {
        logic [15:0]        chg_limit_da;
        logic [15:0]        dis_limit_da;
        logic [30:0]        excess_charge_level;
        logic [30:0]        excess_discharge_level;
        logic signed [31:0] soft_level;
        logic [1:0]         over_limit;
    } clim_out_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARGE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISCHARGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USER_CHARGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USER_DISCHARGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_MARGIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_MAX       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_MIN       = 3'd7;

    localparam logic [1:0] OVER_NONE      = 2'd0;
    localparam logic [1:0] OVER_CHARGE    = 2'd1;
    localparam logic [1:0] OVER_DISCHARGE = 2'd2;

    // |current| / 100 as (x * DIV100_K) >> DIV100_SHIFT, exact for x <= 2^21
    localparam int          DIV100_SHIFT = 28;
    localparam logic [21:0] DIV100_K     = 22'd2684355;

    localparam logic [30:0]        BUCKET_MAX = 31'h7FFF_FFFF;
    localparam logic signed [31:0] SOFT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SOFT_MIN   = 32'sh8000_0000;

endpackage

// ----- sv/current_limit_overcurrent_integrator.sv -----
// Current limit and overcurrent integrator: one transaction in, one out per tick.
// Uses clim_pkg. Input register (with |I|/100 precomputed), then limit/bucket
// logic into the result register.
`timescale 1ns / 1ps

// Each input transaction yields one result transaction. The block is a two-
// register pipeline: the input register holds the tick with |current|/100
// already formed by a constant multiply, and the result register is loaded
// from the limit minimum chain and the bucket update. m_valid rises as the
// tick enters the result register. Throughput is one transaction per cycle
// unless m_ready stalls, set by the bucket update each tick takes from the last.
// Configuration writes take effect at the clock edge of cfg_wr_en and must
// only be issued while no transaction is in flight.
module current_limit_overcurrent_integrator
    import clim_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  clim_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output clim_out_t             m_data
);

    // configuration
    logic [15:0]        max_charge_reg, max_discharge_reg;
    logic [15:0]        user_charge_reg, user_discharge_reg;
    logic [15:0]        margin_reg;
    logic [30:0]        bucket_limit_reg;
    logic signed [15:0] soft_max_reg, soft_min_reg;

    // pipeline
    logic        in_valid_reg, out_valid_reg;
    clim_in_t    in_data_reg;
    logic [14:0] mag_reg;
    logic        cur_pos_reg, cur_neg_reg;
    clim_out_t   out_data_reg, out_data_next;

    // state
    logic [30:0]        chg_bucket_reg, chg_bucket_next;
    logic [30:0]        dis_bucket_reg, dis_bucket_next;
    logic signed [31:0] soft_bucket_reg, soft_bucket_next;

    logic        advance;
    logic        accept;
    logic [20:0] abs_cur;
    logic [42:0] div_prod;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign abs_cur  = s_data.meas_ma[20] ? 21'(-s_data.meas_ma) : s_data.meas_ma;
    assign div_prod = 43'(abs_cur) * 43'(DIV100_K);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_charge_reg     <= '0;
            max_discharge_reg  <= '0;
            user_charge_reg    <= '0;
            user_discharge_reg <= '0;
            margin_reg         <= '0;
            bucket_limit_reg   <= BUCKET_MAX;
            soft_max_reg       <= 16'sh7FFF;
            soft_min_reg       <= 16'sh8000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MAX_CHARGE:     max_charge_reg     <= cfg_wdata[15:0];
                REG_MAX_DISCHARGE:  max_discharge_reg  <= cfg_wdata[15:0];
                REG_USER_CHARGE:    user_charge_reg    <= cfg_wdata[15:0];
                REG_USER_DISCHARGE: user_discharge_reg <= cfg_wdata[15:0];
                REG_ERROR_MARGIN:   margin_reg         <= cfg_wdata[15:0];
                REG_BUCKET_LIMIT:   bucket_limit_reg   <= cfg_wdata[30:0];
                REG_SOFT_MAX:       soft_max_reg       <= $signed(cfg_wdata[15:0]);
                REG_SOFT_MIN:       soft_min_reg       <= $signed(cfg_wdata[15:0]);
                default: ;
            endcase
        end
    end

    function automatic logic [15:0] umin16(input logic [15:0] a, input logic [15:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [15:0] apply_user(input logic [15:0] lim,
                                               input logic [15:0] user);
        return (user != 16'd0 && lim > user) ? user - 16'd1 : lim;
    endfunction

    // limits, excess and bucket update
    logic [15:0]        chg_lim, dis_lim;
    logic signed [17:0] ex_chg, ex_dis;
    logic signed [16:0] ex_soft_chg, ex_soft_dis;
    logic [31:0]        chg_sum, dis_sum;
    logic [30:0]        chg_acc, dis_acc;
    logic signed [32:0] soft_sum;
    logic               in_band;

    always_comb begin
        chg_lim = in_data_reg.flow_en ? max_charge_reg : 16'd0;
        dis_lim = in_data_reg.flow_en ? max_discharge_reg : 16'd0;
        chg_lim = umin16(chg_lim, in_data_reg.temp_charge_da);
        dis_lim = umin16(dis_lim, in_data_reg.temp_discharge_da);
        chg_lim = umin16(chg_lim, in_data_reg.cellv_charge_da);
        dis_lim = umin16(dis_lim, in_data_reg.cellv_discharge_da);
        chg_lim = umin16(chg_lim, in_data_reg.working_charge_da);
        chg_lim = umin16(chg_lim, in_data_reg.delta_charge_da);
        chg_lim = apply_user(chg_lim, user_charge_reg);
        dis_lim = apply_user(dis_lim, user_discharge_reg);

        ex_chg = $signed({3'b0, mag_reg}) - $signed({2'b0, chg_lim})
                 - $signed({2'b0, margin_reg});
        ex_dis = $signed({3'b0, mag_reg}) - $signed({2'b0, dis_lim})
                 - $signed({2'b0, margin_reg});

        // a positive excess never exceeds mag, so 15 bits carry it
        chg_sum = {1'b0, chg_bucket_reg} + {17'b0, ex_chg[14:0]};
        dis_sum = {1'b0, dis_bucket_reg} + {17'b0, ex_dis[14:0]};

        chg_acc = chg_bucket_reg;
        if (cur_pos_reg && ex_chg > 18'sd0) begin
            chg_acc = chg_sum[31] ? BUCKET_MAX : chg_sum[30:0];
        end
        dis_acc = dis_bucket_reg;
        if (cur_neg_reg && ex_dis > 18'sd0) begin
            dis_acc = dis_sum[31] ? BUCKET_MAX : dis_sum[30:0];
        end
        chg_bucket_next = (chg_acc != 31'd0) ? chg_acc - 31'd1 : 31'd0;
        dis_bucket_next = (dis_acc != 31'd0) ? dis_acc - 31'd1 : 31'd0;

        // soft bucket: no margin, signed, no decay
        ex_soft_chg = $signed({2'b0, mag_reg}) - $signed({1'b0, chg_lim});
        ex_soft_dis = $signed({2'b0, mag_reg}) - $signed({1'b0, dis_lim});
        in_band = (in_data_reg.cell_max_mv < soft_max_reg)
                  && (in_data_reg.cell_min_mv > soft_min_reg);
        soft_sum = 33'(soft_bucket_reg);
        if (cur_pos_reg && ex_soft_chg > 17'sd0) begin
            soft_sum = 33'(soft_bucket_reg) + 33'(ex_soft_chg);
        end else if (cur_neg_reg && ex_soft_dis > 17'sd0) begin
            soft_sum = 33'(soft_bucket_reg) - 33'(ex_soft_dis);
        end
        if (in_band) begin
            soft_bucket_next = '0;
        end else if (soft_sum[32] != soft_sum[31]) begin
            soft_bucket_next = soft_sum[32] ? SOFT_MIN : SOFT_MAX;
        end else begin
            soft_bucket_next = soft_sum[31:0];
        end

        out_data_next.chg_limit_da           = chg_lim;
        out_data_next.dis_limit_da           = dis_lim;
        out_data_next.excess_charge_level    = chg_bucket_next;
        out_data_next.excess_discharge_level = dis_bucket_next;
        out_data_next.soft_level             = soft_bucket_next;
        if (chg_bucket_next > bucket_limit_reg) begin
            out_data_next.over_limit = OVER_CHARGE;
        end else if (dis_bucket_next > bucket_limit_reg) begin
            out_data_next.over_limit = OVER_DISCHARGE;
        end else begin
            out_data_next.over_limit = OVER_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            chg_bucket_reg  <= '0;
            dis_bucket_reg  <= '0;
            soft_bucket_reg <= '0;
        end else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg) begin
                chg_bucket_reg  <= chg_bucket_next;
                dis_bucket_reg  <= dis_bucket_next;
                soft_bucket_reg <= soft_bucket_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_data_reg <= s_data;
            mag_reg     <= div_prod[DIV100_SHIFT+14:DIV100_SHIFT];
            cur_pos_reg <= !s_data.meas_ma[20] && (s_data.meas_ma != 21'sd0);
            cur_neg_reg <= s_data.meas_ma[20];
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    // buckets move only when a transaction enters the result register
    a_bucket_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_valid_reg) |=> $stable(chg_bucket_reg) && $stable(dis_bucket_reg)
            && $stable(soft_bucket_reg))
        else $error("bucket changed without a transaction");

    // a waiting result always mirrors the live bucket state
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.excess_charge_level == chg_bucket_reg)
            && (m_data.excess_discharge_level == dis_bucket_reg)
            && (m_data.soft_level == soft_bucket_reg))
        else $error("result out of step with bucket state");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg))
        else $error("result valid without an input transaction");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && chg_bucket_reg == 31'd0 && soft_bucket_reg == 32'sd0)
        else $error("reset did not clear pipeline state");

endmodule
